[design/mrrc_pkg.sv]
// Package for the memory region registry checker: sizes, command codes,
// state machine encoding and the controller/datapath command struct.
// No dependencies.
`timescale 1ns / 1ps

package mrrc_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] CMD_RECORD   = 3'd0;
    localparam logic [2:0] CMD_UNRECORD = 3'd1;
    localparam logic [2:0] CMD_CONFLICT = 3'd2;
    localparam logic [2:0] CMD_ACCESS   = 3'd3;
    localparam logic [2:0] CMD_VALIDATE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Scan kinds run by the datapath
    typedef enum logic [2:0] {
        SCAN_KEY,     // key lookup, free slot, any valid entry, succ(>=) and pred(<) of key
        SCAN_BACK,    // pred of run head start
        SCAN_FWD,     // strict succ of run tail start
        SCAN_NONE
    } scan_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_BACK,
        S_BACK_CHK,
        S_FWD,
        S_FWD_CHK,
        S_RUN_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic            start;     // begin a scan
        scan_t           kind;
        logic            tbl;       // 1 server, 0 client
        logic [63:0]     key;
        logic            wr_en;     // store a region at free slot
        logic            del_en;    // drop key slot
        logic [IDX_W-1:0] slot;
        logic [63:0]     wr_start;
        logic [63:0]     wr_len;
    } dp_cmd_t;

    typedef struct packed {
        logic             done;
        logic             key_hit;
        logic [IDX_W-1:0] key_idx;
        logic             free_hit;
        logic [IDX_W-1:0] free_idx;
        logic             any;
        logic             succ_hit;
        logic [63:0]      succ_start;
        logic [63:0]      succ_end;
        logic             pred_hit;
        logic [63:0]      pred_start;
        logic [63:0]      pred_end;
    } dp_stat_t;

endpackage

[design/mrrc_if.sv]
// Valid/ready channel carrying a payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps

interface mrrc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/mrrc_datapath.sv]
// Datapath: both region tables in memories and a one-entry-a-cycle scanner.
// Depends on mrrc_pkg.
`timescale 1ns / 1ps

module mrrc_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  mrrc_pkg::dp_cmd_t  cmd,
    output mrrc_pkg::dp_stat_t stat
);
    localparam int IW = mrrc_pkg::IDX_W;

    logic [mrrc_pkg::TABLE_ENTRIES-1:0] sv_valid_reg, cl_valid_reg;
    logic [63:0] sv_start_mem [mrrc_pkg::TABLE_ENTRIES];
    logic [63:0] sv_len_mem   [mrrc_pkg::TABLE_ENTRIES];
    logic [63:0] cl_start_mem [mrrc_pkg::TABLE_ENTRIES];
    logic [63:0] cl_len_mem   [mrrc_pkg::TABLE_ENTRIES];

    // scan control
    logic                   busy_reg;
    logic                   rd_v_reg;     // a read is in flight
    logic [IW:0]            ptr_reg;
    logic [IW-1:0]          rd_idx_reg;
    mrrc_pkg::scan_t        kind_reg;
    logic                   tbl_reg;
    logic [63:0]            key_reg;
    logic [63:0]            rs_reg, rl_reg;
    logic                   rvalid_reg;
    logic                   done_reg;

    // results
    logic             key_hit_reg, free_hit_reg, any_reg, succ_hit_reg, pred_hit_reg;
    logic [IW-1:0]    key_idx_reg, free_idx_reg;
    logic [63:0]      succ_s_reg, succ_l_reg, pred_s_reg, pred_l_reg;

    logic [IW-1:0] rd_idx;
    assign rd_idx = ptr_reg[IW-1:0];

    // table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.tbl)
        begin
            sv_start_mem[cmd.slot] <= cmd.wr_start;
            sv_len_mem[cmd.slot]   <= cmd.wr_len;
        end
        if (cmd.wr_en && !cmd.tbl)
        begin
            cl_start_mem[cmd.slot] <= cmd.wr_start;
            cl_len_mem[cmd.slot]   <= cmd.wr_len;
        end
        rs_reg <= tbl_reg ? sv_start_mem[rd_idx] : cl_start_mem[rd_idx];
        rl_reg <= tbl_reg ? sv_len_mem[rd_idx]   : cl_len_mem[rd_idx];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_valid_reg <= '0;
            cl_valid_reg <= '0;
        end
        else
        begin
            if (cmd.wr_en && cmd.tbl)   sv_valid_reg[cmd.slot] <= 1'b1;
            if (cmd.wr_en && !cmd.tbl)  cl_valid_reg[cmd.slot] <= 1'b1;
            if (cmd.del_en && cmd.tbl)  sv_valid_reg[cmd.slot] <= 1'b0;
            if (cmd.del_en && !cmd.tbl) cl_valid_reg[cmd.slot] <= 1'b0;
        end
    end

    // scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            ptr_reg  <= '0;
            done_reg <= 1'b0;
            kind_reg <= mrrc_pkg::SCAN_NONE;
            tbl_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                ptr_reg  <= '0;
                rd_v_reg <= 1'b0;
                kind_reg <= cmd.kind;
                tbl_reg  <= cmd.tbl;
            end
            else if (busy_reg)
            begin
                rd_v_reg <= (ptr_reg < (IW+1)'(mrrc_pkg::TABLE_ENTRIES));
                if (ptr_reg < (IW+1)'(mrrc_pkg::TABLE_ENTRIES))
                    ptr_reg <= ptr_reg + 1'b1;
                if (!(ptr_reg < (IW+1)'(mrrc_pkg::TABLE_ENTRIES)) && !rd_v_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // pipeline the index and valid alongside the read
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            key_reg <= cmd.key;
        rd_idx_reg <= rd_idx;
        rvalid_reg <= tbl_reg ? sv_valid_reg[rd_idx] : cl_valid_reg[rd_idx];
    end

    // compare one entry a cycle
    logic want_succ, want_pred;
    logic [63:0] re;
    assign re = rs_reg + rl_reg;
    always_comb
    begin
        want_succ = 1'b0;
        want_pred = 1'b0;
        unique case (kind_reg)
            mrrc_pkg::SCAN_KEY:  begin want_succ = rs_reg >= key_reg; want_pred = rs_reg < key_reg; end
            mrrc_pkg::SCAN_BACK: want_pred = rs_reg < key_reg;
            mrrc_pkg::SCAN_FWD:  want_succ = rs_reg > key_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_hit_reg  <= 1'b0;
            free_hit_reg <= 1'b0;
            any_reg      <= 1'b0;
            succ_hit_reg <= 1'b0;
            pred_hit_reg <= 1'b0;
        end
        else if (rd_v_reg)
        begin
            if (!rvalid_reg && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            if (rvalid_reg)
            begin
                any_reg <= 1'b1;
                if (rs_reg == key_reg && !key_hit_reg)
                begin
                    key_hit_reg <= 1'b1;
                    key_idx_reg <= rd_idx_reg;
                end
                if (want_succ && (!succ_hit_reg || rs_reg < succ_s_reg))
                begin
                    succ_hit_reg <= 1'b1;
                    succ_s_reg   <= rs_reg;
                    succ_l_reg   <= re;
                end
                if (want_pred && (!pred_hit_reg || rs_reg > pred_s_reg))
                begin
                    pred_hit_reg <= 1'b1;
                    pred_s_reg   <= rs_reg;
                    pred_l_reg   <= re;
                end
            end
        end
    end

    assign stat.done       = done_reg;
    assign stat.key_hit    = key_hit_reg;
    assign stat.key_idx    = key_idx_reg;
    assign stat.free_hit   = free_hit_reg;
    assign stat.free_idx   = free_idx_reg;
    assign stat.any        = any_reg;
    assign stat.succ_hit   = succ_hit_reg;
    assign stat.succ_start = succ_s_reg;
    assign stat.succ_end   = succ_l_reg;
    assign stat.pred_hit   = pred_hit_reg;
    assign stat.pred_start = pred_s_reg;
    assign stat.pred_end   = pred_l_reg;

endmodule

[design/mrrc_ctrl.sv]
// Controller: takes a command beat, sequences table scans, forms the result.
// Depends on mrrc_pkg.
`timescale 1ns / 1ps

module mrrc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_cmd,
    input  logic               in_side,
    input  logic [63:0]        in_addr,
    input  logic [63:0]        in_length,
    input  logic [63:0]        in_peer,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic               out_verdict,
    output mrrc_pkg::dp_cmd_t  dp,
    input  mrrc_pkg::dp_stat_t st
);
    mrrc_pkg::state_t state_reg, state_next;

    logic [2:0]  cmd_reg;
    logic        side_reg;
    logic [63:0] addr_reg, len_reg, peer_reg;
    logic        phase_reg, phase_next;     // validate: 0 server, 1 client
    logic [1:0]  status_reg, status_next;
    logic        verdict_reg, verdict_next;
    logic [63:0] s_reg, s_next;            // access start of current check
    logic [63:0] e_reg, e_next;            // access end
    logic [63:0] a_start_reg, a_start_next; // run head start
    logic [63:0] b_start_reg, b_start_next; // run tail start
    logic [63:0] b_end_reg, b_end_next;     // run tail end
    logic        multi_reg, multi_next;     // run has two regions or more
    logic        res_valid_reg, res_valid_next;
    logic [mrrc_pkg::IDX_W+1:0] steps_reg, steps_next;

    logic        tbl;
    logic        is_access;
    logic        ovf;
    logic [63:0] n_end;
    logic        ovl_s, ovl_p, in_s, in_p;
    logic        acc_fail;

    assign is_access = (cmd_reg == mrrc_pkg::CMD_ACCESS) || (cmd_reg == mrrc_pkg::CMD_VALIDATE);
    assign tbl   = (cmd_reg == mrrc_pkg::CMD_VALIDATE) ? !phase_reg : side_reg;
    assign n_end = s_reg + len_reg;
    assign ovf   = n_end < s_reg;

    assign ovl_s = st.succ_hit && (s_reg < st.succ_end) && (st.succ_start < n_end)
                   && !((s_reg == st.succ_start) && (n_end == st.succ_end));
    assign ovl_p = st.pred_hit && (s_reg < st.pred_end) && (st.pred_start < n_end)
                   && !((s_reg == st.pred_start) && (n_end == st.pred_end));
    assign in_s  = st.succ_hit && (s_reg >= st.succ_start) && (n_end <= st.succ_end);
    assign in_p  = st.pred_hit && (s_reg >= st.pred_start) && (n_end <= st.pred_end);

    // access precheck failure for the current table
    assign acc_fail = (s_reg == 64'd0) || (len_reg == 64'd0) || !st.any || ovf;

    // input capture and state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrrc_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= in_cmd;
            side_reg <= in_side;
            addr_reg <= in_addr;
            len_reg  <= in_length;
            peer_reg <= in_peer;
        end
        phase_reg   <= phase_next;
        status_reg  <= status_next;
        verdict_reg <= verdict_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        a_start_reg <= a_start_next;
        b_start_reg <= b_start_next;
        b_end_reg   <= b_end_next;
        multi_reg   <= multi_next;
        steps_reg   <= steps_next;
    end

    // next state and datapath working values
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        status_next    = status_reg;
        verdict_next   = verdict_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        a_start_next   = a_start_reg;
        b_start_next   = b_start_reg;
        b_end_next     = b_end_reg;
        multi_next     = multi_reg;
        steps_next     = steps_reg;
        res_valid_next = res_valid_reg;
        unique case (state_reg)
            mrrc_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next   = mrrc_pkg::S_SCAN;
                    phase_next   = 1'b0;
                    status_next  = mrrc_pkg::ST_OK;
                    verdict_next = 1'b0;
                    s_next       = in_addr;
                end
            end
            mrrc_pkg::S_SCAN:
            begin
                if (st.done)
                    state_next = mrrc_pkg::S_DECIDE;
            end
            mrrc_pkg::S_DECIDE:
            begin
                state_next = mrrc_pkg::S_OUT;
                priority case (1'b1)
                    cmd_reg == mrrc_pkg::CMD_RECORD:
                    begin
                        if (st.key_hit)
                            status_next = side_reg ? mrrc_pkg::ST_OK : mrrc_pkg::ST_INVALID;
                        else if (!st.free_hit)
                            status_next = mrrc_pkg::ST_FULL;
                    end
                    cmd_reg == mrrc_pkg::CMD_UNRECORD:
                    begin
                        if (!st.key_hit)
                            status_next = mrrc_pkg::ST_INVALID;
                    end
                    cmd_reg == mrrc_pkg::CMD_CONFLICT:
                    begin
                        verdict_next = (s_reg == 64'd0) || (len_reg == 64'd0)
                                       || (st.any && (ovl_s || ovl_p));
                    end
                    is_access:
                    begin
                        if ((cmd_reg == mrrc_pkg::CMD_VALIDATE) &&
                            ((addr_reg == 64'd0) || (peer_reg == 64'd0) || (len_reg == 64'd0)))
                            status_next = mrrc_pkg::ST_INVALID;
                        else if (acc_fail || (!in_s && !in_p && !st.succ_hit))
                        begin
                            if (cmd_reg == mrrc_pkg::CMD_VALIDATE)
                                status_next = mrrc_pkg::ST_INVALID;
                        end
                        else if (in_s || in_p)
                        begin
                            if (cmd_reg == mrrc_pkg::CMD_ACCESS)
                                verdict_next = 1'b1;
                            else if (!phase_reg)
                            begin
                                phase_next = 1'b1;
                                s_next     = peer_reg;
                                state_next = mrrc_pkg::S_SCAN;
                            end
                        end
                        else
                        begin
                            // grow a run around the successor
                            e_next       = n_end;
                            a_start_next = st.succ_start;
                            b_start_next = st.succ_start;
                            b_end_next   = st.succ_end;
                            multi_next   = 1'b0;
                            steps_next   = '0;
                            state_next   = mrrc_pkg::S_BACK;
                        end
                    end
                    default:
                        status_next = mrrc_pkg::ST_INVALID;
                endcase
            end
            mrrc_pkg::S_BACK:
            begin
                if (st.done)
                    state_next = mrrc_pkg::S_BACK_CHK;
            end
            mrrc_pkg::S_BACK_CHK:
            begin
                steps_next = steps_reg + 1'b1;
                if (st.pred_hit && (st.pred_end == a_start_reg) &&
                    (steps_reg < (mrrc_pkg::IDX_W+2)'(mrrc_pkg::TABLE_ENTRIES - 1)))
                begin
                    a_start_next = st.pred_start;
                    multi_next   = 1'b1;
                    state_next   = mrrc_pkg::S_BACK;
                end
                else
                begin
                    steps_next = '0;
                    state_next = mrrc_pkg::S_FWD;
                end
            end
            mrrc_pkg::S_FWD:
            begin
                if (st.done)
                    state_next = mrrc_pkg::S_FWD_CHK;
            end
            mrrc_pkg::S_FWD_CHK:
            begin
                steps_next = steps_reg + 1'b1;
                if (st.succ_hit && (b_end_reg == st.succ_start) &&
                    (steps_reg < (mrrc_pkg::IDX_W+2)'(mrrc_pkg::TABLE_ENTRIES - 1)))
                begin
                    b_start_next = st.succ_start;
                    b_end_next   = st.succ_end;
                    multi_next   = 1'b1;
                    state_next   = mrrc_pkg::S_FWD;
                end
                else
                    state_next = mrrc_pkg::S_RUN_CHK;
            end
            mrrc_pkg::S_RUN_CHK:
            begin
                state_next = mrrc_pkg::S_OUT;
                if (multi_reg && (s_reg >= a_start_reg) && (e_reg <= b_end_reg))
                begin
                    if (cmd_reg == mrrc_pkg::CMD_ACCESS)
                        verdict_next = 1'b1;
                    else if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        s_next     = peer_reg;
                        state_next = mrrc_pkg::S_SCAN;
                    end
                end
                else if (cmd_reg == mrrc_pkg::CMD_VALIDATE)
                    status_next = mrrc_pkg::ST_INVALID;
            end
            mrrc_pkg::S_OUT:
            begin
                res_valid_next = 1'b1;
                state_next     = mrrc_pkg::S_IDLE;
            end
            default:
                state_next = mrrc_pkg::S_IDLE;
        endcase
        if (res_valid_reg && out_ready)
            res_valid_next = 1'b0;
        if (state_reg == mrrc_pkg::S_OUT)
            res_valid_next = 1'b1;
    end

    // outputs and datapath commands
    always_comb
    begin
        in_ready    = (state_reg == mrrc_pkg::S_IDLE) && (!res_valid_reg || out_ready);
        out_valid   = res_valid_reg;
        out_status  = status_reg;
        out_verdict = verdict_reg;
        dp          = '0;
        dp.kind     = mrrc_pkg::SCAN_NONE;
        dp.tbl      = tbl;
        dp.wr_start = addr_reg;
        dp.wr_len   = len_reg;
        unique case (state_reg)
            mrrc_pkg::S_IDLE:
            begin
                dp.start = in_valid && in_ready;
                dp.kind  = mrrc_pkg::SCAN_KEY;
                dp.tbl   = (in_cmd == mrrc_pkg::CMD_VALIDATE) ? 1'b1 : in_side;
                dp.key   = in_addr;
            end
            mrrc_pkg::S_DECIDE:
            begin
                // client pass of validate reads the client table; writes use the command's table
                dp.start = (state_next == mrrc_pkg::S_SCAN);
                dp.kind  = mrrc_pkg::SCAN_KEY;
                dp.tbl   = (state_next == mrrc_pkg::S_SCAN) ? 1'b0 : tbl;
                dp.key   = peer_reg;
                if (state_next == mrrc_pkg::S_BACK)
                begin
                    dp.start = 1'b1;
                    dp.kind  = mrrc_pkg::SCAN_BACK;
                    dp.tbl   = tbl;
                    dp.key   = st.succ_start;
                end
                dp.wr_en  = (cmd_reg == mrrc_pkg::CMD_RECORD) && !st.key_hit && st.free_hit;
                dp.del_en = (cmd_reg == mrrc_pkg::CMD_UNRECORD) && st.key_hit;
                dp.slot   = (cmd_reg == mrrc_pkg::CMD_RECORD) ? st.free_idx : st.key_idx;
            end
            mrrc_pkg::S_BACK_CHK:
            begin
                dp.start = 1'b1;
                dp.kind  = (state_next == mrrc_pkg::S_BACK) ? mrrc_pkg::SCAN_BACK
                                                            : mrrc_pkg::SCAN_FWD;
                dp.key   = (state_next == mrrc_pkg::S_BACK) ? st.pred_start : b_start_reg;
            end
            mrrc_pkg::S_FWD_CHK:
            begin
                dp.start = (state_next == mrrc_pkg::S_FWD);
                dp.kind  = mrrc_pkg::SCAN_FWD;
                dp.key   = st.succ_start;
            end
            mrrc_pkg::S_RUN_CHK:
            begin
                dp.start = (state_next == mrrc_pkg::S_SCAN);
                dp.kind  = mrrc_pkg::SCAN_KEY;
                dp.tbl   = 1'b0;
                dp.key   = peer_reg;
            end
            default: ;
        endcase
    end

endmodule

[design/memory_region_registry_checker.sv]
// Memory region registry checker: each command scans a 32-entry region table
// one entry per cycle. Record, unrecord and overlap checks take one scan. An
// access check takes one scan when a single region holds it; otherwise it adds
// one scan per region of the merged run plus one more; validate runs that for
// both tables. One command is in flight at a time; a result waits in an output
// register and the next command may be taken in the cycle that result is taken.
`timescale 1ns / 1ps

module memory_region_registry_checker
(
    input logic clk,
    input logic rst_n,
    mrrc_if.sink   cmd_in,
    mrrc_if.source res_out
);
    mrrc_pkg::dp_cmd_t  dp;
    mrrc_pkg::dp_stat_t st;

    mrrc_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cmd_in.valid),
        .in_ready    (cmd_in.ready),
        .in_cmd      (cmd_in.data.cmd),
        .in_side     (cmd_in.data.side),
        .in_addr     (cmd_in.data.addr),
        .in_length   (cmd_in.data.length),
        .in_peer     (cmd_in.data.peer_addr),
        .out_valid   (res_out.valid),
        .out_ready   (res_out.ready),
        .out_status  (res_out.data.status),
        .out_verdict (res_out.data.verdict),
        .dp          (dp),
        .st          (st)
    );

    mrrc_datapath u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dp),
        .stat  (st)
    );

endmodule

[design/mrrc_checker.sv]
// Port-level checks for the registry checker, bound to the top level.
// Depends on the top level's ports.
`timescale 1ns / 1ps

module mrrc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic       verdict
);
    // a held result beat stays stable
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(verdict))
        else $error("result changed while stalled");

    // no new command beat the cycle after one is taken
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second command taken while busy");

    // status never shows the unused code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");

    // verdict only with success status
    a_vd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict |-> status == 2'd0)
        else $error("verdict with failure status");
endmodule

bind memory_region_registry_checker mrrc_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd_in.valid),
    .in_ready  (cmd_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .status    (res_out.data.status),
    .verdict   (res_out.data.verdict)
);

[sim/tb_memory_region_registry_checker.sv]
// Testbench for memory_region_registry_checker: directed and random command beats
// checked against a region table predictor held in a small scoreboard class.
// Depends on mrrc_pkg, mrrc_if and the checker RTL.
`timescale 1ns / 1ps

package mrrc_tb_pkg;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        side;
        logic [63:0] addr;
        logic [63:0] length;
        logic [63:0] peer_addr;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       verdict;
    } res_t;

    // Region table predictor and store of expected answers
    class region_scoreboard;
        bit          used [2][mrrc_pkg::TABLE_ENTRIES];
        logic [63:0] base [2][mrrc_pkg::TABLE_ENTRIES];
        logic [63:0] size [2][mrrc_pkg::TABLE_ENTRIES];
        res_t        answers [$];
        int          fails;

        function new();
            fails = 0;
            foreach (used[t, i]) used[t][i] = 0;
        endfunction

        function int find_start(bit sd, logic [63:0] key);
            for (int i = 0; i < mrrc_pkg::TABLE_ENTRIES; i++)
                if (used[sd][i] && base[sd][i] == key) return i;
            return -1;
        endfunction

        function int occupancy(bit sd);
            int n;
            n = 0;
            for (int i = 0; i < mrrc_pkg::TABLE_ENTRIES; i++) if (used[sd][i]) n++;
            return n;
        endfunction

        // lowest start >= key, or > key when strict
        function int next_region(bit sd, logic [63:0] key, bit strict);
            int best;
            best = -1;
            for (int i = 0; i < mrrc_pkg::TABLE_ENTRIES; i++) begin
                if (!used[sd][i]) continue;
                if (strict ? (base[sd][i] <= key) : (base[sd][i] < key)) continue;
                if (best < 0 || base[sd][i] < base[sd][best]) best = i;
            end
            return best;
        endfunction

        // highest start < key
        function int prev_region(bit sd, logic [63:0] key);
            int best;
            best = -1;
            for (int i = 0; i < mrrc_pkg::TABLE_ENTRIES; i++) begin
                if (!used[sd][i] || base[sd][i] >= key) continue;
                if (best < 0 || base[sd][i] > base[sd][best]) best = i;
            end
            return best;
        endfunction

        function logic [63:0] region_end(bit sd, int i);
            return base[sd][i] + size[sd][i];
        endfunction

        function bit clash(logic [63:0] s, logic [63:0] e, logic [63:0] rs, logic [63:0] re);
            return (s < re) && (rs < e) && !((s == rs) && (e == re));
        endfunction

        function bit overlap_conflict(bit sd, logic [63:0] s, logic [63:0] n);
            int          nx, pv;
            logic [63:0] e;
            if (s == 0 || n == 0) return 1;
            if (occupancy(sd) == 0) return 0;
            e  = s + n;
            nx = next_region(sd, s, 0);
            if (nx >= 0 && clash(s, e, base[sd][nx], region_end(sd, nx))) return 1;
            pv = prev_region(sd, s);
            if (pv >= 0 && clash(s, e, base[sd][pv], region_end(sd, pv))) return 1;
            return 0;
        endfunction

        function bit access_allowed(bit sd, logic [63:0] s, logic [63:0] n);
            int          nx, pv, head, tail, q;
            logic [63:0] e;
            if (s == 0 || n == 0) return 0;
            if (occupancy(sd) == 0) return 0;
            if (n > ~s) return 0;
            e  = s + n;
            nx = next_region(sd, s, 0);
            if (nx >= 0 && s >= base[sd][nx] && e <= region_end(sd, nx)) return 1;
            pv = prev_region(sd, s);
            if (pv >= 0 && s >= base[sd][pv] && e <= region_end(sd, pv)) return 1;
            if (nx < 0) return 0;
            // grow the merged run backward and forward from the successor
            head = nx;
            for (int k = 0; k < mrrc_pkg::TABLE_ENTRIES; k++) begin
                q = prev_region(sd, base[sd][head]);
                if (q < 0 || region_end(sd, q) != base[sd][head]) break;
                head = q;
            end
            tail = nx;
            for (int k = 0; k < mrrc_pkg::TABLE_ENTRIES; k++) begin
                q = next_region(sd, base[sd][tail], 1);
                if (q < 0 || region_end(sd, tail) != base[sd][q]) break;
                tail = q;
            end
            if (head == tail) return 0;
            return (s >= base[sd][head]) && (e <= region_end(sd, tail));
        endfunction

        // Work out the answer to an accepted command beat and update the tables
        function void note_command(req_t r);
            res_t a;
            int   i;
            a = '0;
            case (r.cmd)
                mrrc_pkg::CMD_RECORD: begin
                    if (find_start(r.side, r.addr) >= 0) begin
                        a.status = r.side ? mrrc_pkg::ST_OK : mrrc_pkg::ST_INVALID;
                    end
                    else begin
                        for (i = 0; i < mrrc_pkg::TABLE_ENTRIES; i++)
                            if (!used[r.side][i]) break;
                        if (i >= mrrc_pkg::TABLE_ENTRIES) a.status = mrrc_pkg::ST_FULL;
                        else begin
                            used[r.side][i] = 1;
                            base[r.side][i] = r.addr;
                            size[r.side][i] = r.length;
                        end
                    end
                end
                mrrc_pkg::CMD_UNRECORD: begin
                    i = find_start(r.side, r.addr);
                    if (i < 0) a.status = mrrc_pkg::ST_INVALID;
                    else used[r.side][i] = 0;
                end
                mrrc_pkg::CMD_CONFLICT: a.verdict = overlap_conflict(r.side, r.addr, r.length);
                mrrc_pkg::CMD_ACCESS:   a.verdict = access_allowed(r.side, r.addr, r.length);
                mrrc_pkg::CMD_VALIDATE: begin
                    if (r.addr == 0 || r.peer_addr == 0 || r.length == 0)
                        a.status = mrrc_pkg::ST_INVALID;
                    else if (!access_allowed(1'b1, r.addr, r.length))
                        a.status = mrrc_pkg::ST_INVALID;
                    else if (!access_allowed(1'b0, r.peer_addr, r.length))
                        a.status = mrrc_pkg::ST_INVALID;
                end
                default: a.status = mrrc_pkg::ST_INVALID;
            endcase
            answers.push_back(a);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (answers.size() == 0) begin
                $error("result beat with nothing expected: status %0d verdict %0d",
                       got.status, got.verdict);
                fails++;
                return;
            end
            want = answers.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fails++;
            end
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
                fails++;
            end
        endfunction
    endclass

endpackage

module tb_memory_region_registry_checker;

    localparam int  RANDOM_BEATS = 1930;
    localparam int  CYCLE_LIMIT  = 50000000;
    localparam bit  SERVER       = 1'b1;
    localparam bit  CLIENT       = 1'b0;

    logic clk;
    logic rst_n;
    int   phase;
    int   cycles;

    mrrc_tb_pkg::region_scoreboard sb;

    mrrc_if #(.T(mrrc_tb_pkg::req_t)) cmd_in ();
    mrrc_if #(.T(mrrc_tb_pkg::res_t)) res_out ();

    memory_region_registry_checker dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_in.sink),
        .res_out (res_out.source)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Result side: random stall by phase, checks taken beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_out.ready <= 1'b0;
        end
        else begin
            if (res_out.valid && res_out.ready) sb.check_result(res_out.data);
            case (phase)
                0:       res_out.ready <= ($urandom_range(0, 99) >= 79);
                1:       res_out.ready <= ($urandom_range(0, 99) >= 14);
                default: res_out.ready <= 1'b1;
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("memory_region_registry_checker regression: fail");
            $finish;
        end
    end

    // One command beat, with a sender gap drawn by phase
    task automatic send(input logic [2:0] cmd, input bit sd, input logic [63:0] addr,
                        input logic [63:0] len, input logic [63:0] peer);
        mrrc_tb_pkg::req_t r;
        int   gap;
        r   = '{cmd: cmd, side: sd, addr: addr, length: len, peer_addr: peer};
        gap = 0;
        if (phase == 0 && $urandom_range(0, 99) < 14) gap = $urandom_range(1, 4);
        if (phase == 1 && $urandom_range(0, 99) < 79) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            cmd_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_in.valid <= 1'b1;
        cmd_in.data  <= r;
        do @(posedge clk); while (!cmd_in.ready);
        sb.note_command(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random command: mostly small aligned regions so runs and hits occur
    task automatic send_random();
        logic [2:0]  cmd;
        bit          sd;
        logic [63:0] addr, len, peer;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)      cmd = mrrc_pkg::CMD_RECORD;
        else if (pick < 52) cmd = mrrc_pkg::CMD_UNRECORD;
        else if (pick < 67) cmd = mrrc_pkg::CMD_CONFLICT;
        else if (pick < 84) cmd = mrrc_pkg::CMD_ACCESS;
        else if (pick < 97) cmd = mrrc_pkg::CMD_VALIDATE;
        else                cmd = 3'($urandom_range(5, 7));
        sd   = $urandom_range(0, 1);
        addr = 64'($urandom_range(1, 48)) << 8;
        peer = 64'($urandom_range(1, 48)) << 8;
        len  = (cmd == mrrc_pkg::CMD_RECORD) ? 64'h100 : 64'($urandom_range(1, 0)) << 8;
        if (cmd != mrrc_pkg::CMD_RECORD)
            len = 64'($urandom_range(0, 0)) + 64'($urandom_range(1, 5) << 7);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            addr = rand64();
            len  = rand64();
            peer = rand64();
        end
        else if (pick < 9) begin
            addr = ~64'($urandom_range(0, 300));
            len  = 64'($urandom_range(0, 400));
        end
        else if (pick < 12) begin
            len = (pick == 9) ? 64'd0 : 64'($urandom_range(1, 600));
        end
        else if (pick < 14) begin
            addr = (pick == 12) ? 64'd0 : addr;
            peer = (pick == 13) ? 64'd0 : peer;
        end
        send(cmd, sd, addr, len, peer);
    endtask

    initial
    begin
        sb            = new();
        phase         = 0;
        rst_n         = 1'b0;
        cmd_in.valid  = 1'b0;
        cmd_in.data   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, duplicates, merged run, overflow, zero cases
        send(mrrc_pkg::CMD_ACCESS,   CLIENT, 64'h1000, 64'h10, 0);
        send(mrrc_pkg::CMD_CONFLICT, CLIENT, 64'h1000, 64'h10, 0);
        send(mrrc_pkg::CMD_RECORD,   SERVER, 64'h1000, 64'h1000, 0);
        send(mrrc_pkg::CMD_RECORD,   SERVER, 64'h1000, 64'h1000, 0);
        send(mrrc_pkg::CMD_RECORD,   CLIENT, 64'h1000, 64'h1000, 0);
        send(mrrc_pkg::CMD_RECORD,   CLIENT, 64'h1000, 64'h800, 0);
        send(mrrc_pkg::CMD_RECORD,   SERVER, 64'h2000, 64'h1000, 0);
        send(mrrc_pkg::CMD_RECORD,   SERVER, 64'h3000, 64'h1000, 0);
        send(mrrc_pkg::CMD_ACCESS,   SERVER, 64'h1800, 64'h1000, 0);
        send(mrrc_pkg::CMD_ACCESS,   SERVER, 64'h1000, 64'h3000, 0);
        send(mrrc_pkg::CMD_ACCESS,   SERVER, 64'h1000, 64'h3001, 0);
        send(mrrc_pkg::CMD_ACCESS,   SERVER, 64'h0, 64'h10, 0);
        send(mrrc_pkg::CMD_ACCESS,   SERVER, 64'h1000, 64'h0, 0);
        send(mrrc_pkg::CMD_RECORD,   SERVER, 64'hFFFF_FFFF_FFFF_FFF0,
             64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(mrrc_pkg::CMD_ACCESS,   SERVER, 64'hFFFF_FFFF_FFFF_FFFF, 64'h2, 0);
        send(mrrc_pkg::CMD_CONFLICT, SERVER, 64'h0, 64'h10, 0);
        send(mrrc_pkg::CMD_CONFLICT, SERVER, 64'h1000, 64'h1000, 0);
        send(mrrc_pkg::CMD_CONFLICT, SERVER, 64'h1800, 64'h100, 0);
        send(mrrc_pkg::CMD_VALIDATE, CLIENT, 64'h1000, 64'h800, 64'h1000);
        send(mrrc_pkg::CMD_VALIDATE, SERVER, 64'h1000, 64'h800, 64'h0);
        send(mrrc_pkg::CMD_UNRECORD, CLIENT, 64'h5000, 64'h0, 0);
        send(mrrc_pkg::CMD_UNRECORD, SERVER, 64'h2000, 64'h0, 0);
        send(mrrc_pkg::CMD_RECORD,   SERVER, 64'h9000, 64'h0, 0);
        send(3'd5,                   SERVER, 64'h1000, 64'h10, 0);
        send(3'd7,                   CLIENT, 64'h1000, 64'h10, 0);

        // Random: three idling phases
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            phase = (n * 3) / RANDOM_BEATS;
            send_random();
        end
        cmd_in.valid <= 1'b0;

        while (sb.answers.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.fails == 0 && sb.answers.size() == 0)
            $display("memory_region_registry_checker regression: pass");
        else
            $display("memory_region_registry_checker regression: fail");
        $finish;
    end

endmodule
